FILE: rtl/core/lms_pkg.sv
// Package for the LMS adaptive notch: microcode format, program and register indexes.
`timescale 1ns / 1ps
package lms_pkg;

    // Configuration register indexes
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_STEP   = 1'b1;

    // Reset value of the adaptation rate (about 0.04 in Q0.16)
    localparam logic [15:0] STEP_RESET = 16'd2621;

    // Datapath operation of one microcode step
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_MAC_MUL,
        OP_MAC_ACC,
        OP_ERR,
        OP_MUE,
        OP_UPD_MUL,
        OP_UPD_ACC,
        OP_OUT
    } t_op;

    // Sequencing condition of one microcode step
    typedef enum logic [1:0] {
        CND_NEXT,   // always fall through
        CND_IN,     // hold until a transaction arrives; jump when bypassed
        CND_LOOP,   // jump back until the tap counter hits the last tap
        CND_OUT     // hold until the output register is free, then jump
    } t_cond;

    localparam int UPC_DEPTH = 8;
    typedef logic [2:0] t_upc;

    // Program addresses
    localparam t_upc UPC_WAIT    = 3'd0;
    localparam t_upc UPC_MAC_MUL = 3'd1;
    localparam t_upc UPC_MAC_ACC = 3'd2;
    localparam t_upc UPC_ERR     = 3'd3;
    localparam t_upc UPC_MUE     = 3'd4;
    localparam t_upc UPC_UPD_MUL = 3'd5;
    localparam t_upc UPC_UPD_ACC = 3'd6;
    localparam t_upc UPC_OUT     = 3'd7;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // Control store
    localparam t_uword UCODE [UPC_DEPTH] = '{
        '{op: OP_IDLE,    cond: CND_IN,   target: UPC_OUT},
        '{op: OP_MAC_MUL, cond: CND_NEXT, target: UPC_WAIT},
        '{op: OP_MAC_ACC, cond: CND_LOOP, target: UPC_MAC_MUL},
        '{op: OP_ERR,     cond: CND_NEXT, target: UPC_WAIT},
        '{op: OP_MUE,     cond: CND_NEXT, target: UPC_WAIT},
        '{op: OP_UPD_MUL, cond: CND_NEXT, target: UPC_WAIT},
        '{op: OP_UPD_ACC, cond: CND_LOOP, target: UPC_UPD_MUL},
        '{op: OP_OUT,     cond: CND_OUT,  target: UPC_WAIT}
    };

endpackage

FILE: rtl/core/lms_adaptive_notch_unit.sv
// LMS adaptive notch filter: microcoded sequencer around a multiply-add datapath.
//
// Input channel i_in_valid / o_in_ready carries one Q1.15 sample per transaction;
// output channel o_out_valid / i_out_ready returns one Q1.15 prediction error per
// input. i_cfg_wr_en writes register i_cfg_addr (0 enable, 1 step size) from
// i_cfg_data with no handshake; write only while the block is idle.
// Enabled: each sample runs through the prediction pass, the error step, the
// step-size product and the weight-update pass, each pass a multiply step and an
// accumulate step per tap; no new sample is taken until its error is in the
// output register. Disabled: the sample skips to the output step and comes back
// unchanged; the next sample is taken once it is in the output register.
// Weights and history live in rotating registers read at the head only.
// Reset (synchronous, active low) clears weights, history and output valid,
// disables the filter and loads the default step size.
// A stalled receiver holds the result in the output register; the sequencer
// waits in its output step and takes no new sample until that register frees.
`timescale 1ns / 1ps
module lms_adaptive_notch_unit
    import lms_pkg::*;
#(
    parameter int TAPS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_sample_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample_out,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_addr,
    input  logic        [15:0] i_cfg_data
);

    localparam int CNT_W   = $clog2(TAPS);
    localparam int PROD_W  = 40;
    localparam int ACC_W   = PROD_W + CNT_W;
    localparam int ERR_W   = ACC_W + 2;
    localparam int MUE_W   = 33;
    localparam int DLT_W   = MUE_W + 16;
    localparam int WSUM_W  = 26;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS - 1);
    localparam logic signed [ERR_W-1:0] ERR_RND = ERR_W'(1) <<< 19;
    localparam logic signed [DLT_W-1:0] DLT_RND = DLT_W'(1) <<< 25;

    // Control and configuration registers
    t_upc                   r_pc, n_pc;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_out_valid, n_out_valid;
    logic                   r_enable, n_enable;
    logic [15:0]            r_step, n_step;
    logic signed [23:0]     r_w [TAPS];
    logic signed [23:0]     n_w [TAPS];
    logic signed [15:0]     r_h [TAPS];
    logic signed [15:0]     n_h [TAPS];

    // Datapath registers
    logic signed [15:0]     r_x, n_x;
    logic signed [15:0]     r_res, n_res;
    logic signed [15:0]     r_out, n_out;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [MUE_W-1:0]  r_mue, n_mue;
    logic signed [DLT_W-1:0]  r_dlt, n_dlt;

    t_uword                 uw;
    logic                   in_xfer;
    logic                   out_free;
    logic                   cnt_last;
    logic signed [ERR_W-1:0] err_v;
    logic signed [ERR_W-1:0] err_q;
    logic signed [15:0]     err_sat;
    logic signed [DLT_W-1:0] dlt_q;
    logic signed [WSUM_W-1:0] w_sum;
    logic signed [23:0]     w_sat;

    assign uw           = UCODE[r_pc];
    assign o_in_ready   = (r_pc == UPC_WAIT);
    assign in_xfer      = i_in_valid && o_in_ready;
    assign out_free     = !r_out_valid || i_out_ready;
    assign cnt_last     = (r_cnt == CNT_LAST);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    // Prediction error: round to Q1.15, saturate to 16 bits
    always_comb begin
        err_v = (ERR_W'(r_x) <<< 20) - ERR_W'(r_acc) + ERR_RND;
        err_q = err_v >>> 20;
        if ((err_q[ERR_W-1:15] == '0) || (err_q[ERR_W-1:15] == '1)) begin
            err_sat = err_q[15:0];
        end else if (err_q[ERR_W-1]) begin
            err_sat = 16'sh8000;
        end else begin
            err_sat = 16'sh7FFF;
        end
    end

    // Weight update: round delta to Q4.20, add, saturate to 24 bits
    always_comb begin
        dlt_q = (r_dlt + DLT_RND) >>> 26;
        w_sum = WSUM_W'(r_w[0]) + WSUM_W'(dlt_q);
        if ((w_sum[WSUM_W-1:23] == '0) || (w_sum[WSUM_W-1:23] == '1)) begin
            w_sat = w_sum[23:0];
        end else if (w_sum[WSUM_W-1]) begin
            w_sat = 24'sh800000;
        end else begin
            w_sat = 24'sh7FFFFF;
        end
    end

    // Datapath operation and sequencing for the current control word
    always_comb begin
        n_pc        = r_pc;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_enable    = r_enable;
        n_step      = r_step;
        n_w         = r_w;
        n_h         = r_h;
        n_x         = r_x;
        n_res       = r_res;
        n_out       = r_out;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_mue       = r_mue;
        n_dlt       = r_dlt;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (uw.op)
            OP_IDLE: begin
                if (in_xfer) begin
                    n_x   = i_sample_in;
                    n_res = i_sample_in;
                    n_acc = '0;
                    n_cnt = '0;
                end
            end
            OP_MAC_MUL: begin
                n_prod = r_w[0] * r_h[0];
            end
            OP_MAC_ACC: begin
                n_acc = r_acc + ACC_W'(r_prod);
                for (int i = 0; i < TAPS - 1; i++) begin
                    n_w[i] = r_w[i+1];
                    n_h[i] = r_h[i+1];
                end
                n_w[TAPS-1] = r_w[0];
                n_h[TAPS-1] = r_h[0];
                n_cnt = cnt_last ? '0 : r_cnt + 1'b1;
            end
            OP_ERR: begin
                n_res = err_sat;
                // shift the new sample into the history
                for (int i = 1; i < TAPS; i++) begin
                    n_h[i] = r_h[i-1];
                end
                n_h[0] = r_x;
            end
            OP_MUE: begin
                n_mue = $signed({1'b0, r_step}) * r_res;
            end
            OP_UPD_MUL: begin
                n_dlt = r_mue * r_h[0];
            end
            OP_UPD_ACC: begin
                for (int i = 0; i < TAPS - 1; i++) begin
                    n_w[i] = r_w[i+1];
                    n_h[i] = r_h[i+1];
                end
                n_w[TAPS-1] = w_sat;
                n_h[TAPS-1] = r_h[0];
                n_cnt = cnt_last ? '0 : r_cnt + 1'b1;
            end
            OP_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end
            default: begin
            end
        endcase

        case (uw.cond)
            CND_NEXT: n_pc = r_pc + 1'b1;
            CND_IN: begin
                if (in_xfer) begin
                    n_pc = r_enable ? r_pc + 1'b1 : uw.target;
                end
            end
            CND_LOOP: n_pc = cnt_last ? r_pc + 1'b1 : uw.target;
            CND_OUT: begin
                if (out_free) begin
                    n_pc = uw.target;
                end
            end
            default: n_pc = UPC_WAIT;
        endcase

        // Configuration writes
        if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_ENABLE: n_enable = i_cfg_data[0];
                CFG_STEP:   n_step   = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control state, configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= UPC_WAIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b0;
            r_step      <= STEP_RESET;
            for (int i = 0; i < TAPS; i++) begin
                r_w[i] <= '0;
                r_h[i] <= '0;
            end
        end else begin
            r_pc        <= n_pc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_enable    <= n_enable;
            r_step      <= n_step;
            r_w         <= n_w;
            r_h         <= n_h;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_res  <= n_res;
        r_out  <= n_out;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_mue  <= n_mue;
        r_dlt  <= n_dlt;
    end

endmodule

FILE: rtl/core/lms_chk.sv
// Port checker for the LMS adaptive notch and its bind to the top level.
`timescale 1ns / 1ps
module lms_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic signed [15:0] i_sample_in,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_sample_out,
    input logic               i_cfg_wr_en,
    input logic               i_cfg_addr,
    input logic        [15:0] i_cfg_data
);

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_sample_out))
        else $error("result changed while stalled");

    // One sample in flight: ready drops right after an input transaction
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second sample taken while busy");

    // A new result is only issued from the busy phase
    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result issued while idle");

endmodule

bind lms_adaptive_notch_unit lms_chk u_lms_chk (.*);

FILE: sim/lms_adaptive_notch_unit_tb.sv
// Self-checking testbench for the LMS adaptive notch unit: scoreboard with a predictor model.
`timescale 1ns / 1ps
module lms_adaptive_notch_unit_tb
    import lms_pkg::*;
();

    localparam int TAPS          = 8;
    localparam int DRAIN_CYCLES  = 4 * TAPS + 8;   // result latency plus margin
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_AT       = 300;            // result count that starts the long hold-off
    localparam int HOLD_CYCLES   = 400;
    localparam int CALM_LO       = 900;            // window with no idling on either side
    localparam int CALM_HI       = 1200;
    localparam int EXP_DEPTH     = 16;             // far above the samples ever in flight

    // Predictor of the notch filter plus a ring of expected error samples
    class notch_scoreboard;
        logic               enabled;
        logic        [15:0] mu;
        logic signed [23:0] coef [TAPS];
        logic signed [15:0] delay_line [TAPS];
        logic signed [15:0] exp_ring [EXP_DEPTH];
        int                 exp_head;
        int                 exp_count;
        int                 mismatches;

        function new();
            enabled    = 1'b0;
            mu         = STEP_RESET;
            mismatches = 0;
            exp_head   = 0;
            exp_count  = 0;
            foreach (coef[t]) begin
                coef[t]       = '0;
                delay_line[t] = '0;
            end
        endfunction

        function void report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endfunction

        // Append one expected result at the tail of the ring
        function void store_expected(logic signed [15:0] v);
            if (exp_count == EXP_DEPTH) begin
                report_mismatch("too many results outstanding");
                return;
            end
            exp_ring[(exp_head + exp_count) % EXP_DEPTH] = v;
            exp_count++;
        endfunction

        // Only bit 0 of the enable register is kept; the step size keeps all 16 bits
        function void write_reg(logic idx, logic [15:0] data);
            if (idx == CFG_ENABLE) begin
                enabled = data[0];
            end else begin
                mu = data;
            end
        endfunction

        // Accepted input sample: compute the prediction error and adapt
        function void note_sample(logic signed [15:0] x);
            longint acc, err, err16, d, w;
            int t;
            if (!enabled) begin
                store_expected(x);
                return;
            end
            acc = 0;
            for (t = 0; t < TAPS; t++) begin
                acc += longint'(coef[t]) * longint'(delay_line[t]);
            end
            err   = longint'(x) * 1048576 - acc;
            err16 = (err + 524288) >>> 20;
            if (err16 > 32767) err16 = 32767;
            if (err16 < -32768) err16 = -32768;
            // shift in the new sample, then update each weight with its updated tap
            for (t = TAPS - 1; t > 0; t--) begin
                delay_line[t] = delay_line[t - 1];
            end
            delay_line[0] = x;
            for (t = 0; t < TAPS; t++) begin
                d = longint'(mu) * err16 * longint'(delay_line[t]);
                w = longint'(coef[t]) + ((d + 33554432) >>> 26);
                if (w > 8388607) w = 8388607;
                if (w < -8388608) w = -8388608;
                coef[t] = w[23:0];
            end
            store_expected(err16[15:0]);
        endfunction

        function void check_error(logic signed [15:0] got);
            logic signed [15:0] want;
            if (exp_count == 0) begin
                report_mismatch($sformatf("unexpected result sample_out=%0d", got));
                return;
            end
            want      = exp_ring[exp_head];
            exp_head  = (exp_head + 1) % EXP_DEPTH;
            exp_count--;
            if (got !== want) begin
                report_mismatch($sformatf("sample_out got %0d expected %0d", got, want));
            end
        endfunction

        function int pending();
            return exp_count;
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_sample_in;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_sample_out;
    logic               i_cfg_wr_en;
    logic               i_cfg_addr;
    logic        [15:0] i_cfg_data;

    notch_scoreboard sb;
    int              n_sent;
    int              n_results;
    int              cycles;
    int              hold_left;
    bit              held;

    lms_adaptive_notch_unit #(.TAPS(TAPS)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Offer one sample and wait for its transaction; random gaps before it
    task automatic send_sample(input logic signed [15:0] x);
        bit calm;
        calm = (n_sent >= CALM_LO) && (n_sent < CALM_HI);
        while (!calm && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_sample(x);
        n_sent++;
    endtask

    // Lower valid and wait until every result is back and the block is quiet
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Mostly periodic tones with a little noise, the rest full-range noise
    task automatic run_phase(input int count);
        logic signed [15:0] pattern [16];
        int  period, amp, pos, left, k, j, v;
        bit  tone;
        left   = 0;
        pos    = 0;
        period = 2;
        tone   = 1'b0;
        for (k = 0; k < count; k++) begin
            if (left == 0) begin
                tone   = $urandom_range(99) < 80;
                period = $urandom_range(16, 2);
                amp    = ($urandom_range(3) == 0) ? 32767 : $urandom_range(32767, 1);
                for (j = 0; j < 16; j++) begin
                    v          = int'($urandom_range(2 * amp)) - amp;
                    pattern[j] = v[15:0];
                end
                pos  = 0;
                left = $urandom_range(60, 20);
            end
            if (tone) begin
                v = int'(pattern[pos]) + int'($urandom_range(6)) - 3;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                pos = (pos + 1) % period;
            end else begin
                v = $urandom;
            end
            send_sample(v[15:0]);
            left--;
        end
    endtask

    // Result side: check each transaction, random stalls, one long hold-off
    initial begin
        i_out_ready = 1'b0;
        n_results   = 0;
        hold_left   = 0;
        held        = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_error(o_sample_out);
                n_results++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!held && n_results == HOLD_AT) begin
                held        = 1'b1;
                hold_left   = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (n_results >= CALM_LO && n_results < CALM_HI) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 7);
            end
        end
    end

    // Watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("lms_adaptive_notch_unit regression: fail");
        $finish;
    end

    // Main sequence
    initial begin
        sb          = new();
        n_sent      = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample_in = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr  = CFG_ENABLE;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pass-through after reset, extremes of the sample
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
        send_sample(16'sh0001);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        drain();

        // Enable via a value with upper bits set, fastest rate: drive saturation
        write_reg(CFG_ENABLE, 16'hFFFF);
        write_reg(CFG_STEP, 16'hFFFF);
        repeat (3) begin
            send_sample(16'sh7FFF);
            send_sample(16'sh8000);
        end
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        send_sample(16'sh0000);
        drain();

        // Zero rate: weights frozen while the history still moves
        write_reg(CFG_STEP, 16'h0000);
        send_sample(16'sh4000);
        send_sample(16'shC000);
        send_sample(16'sh7FFF);
        drain();

        // Disable with bit 0 clear but upper bits set: state must stay frozen
        write_reg(CFG_ENABLE, 16'hFFFE);
        send_sample(16'sh1234);
        send_sample(16'sh8001);
        drain();
        write_reg(CFG_ENABLE, 16'h0001);
        send_sample(16'sh0100);
        send_sample(16'shFF00);
        drain();

        // Random phases over several settings
        write_reg(CFG_STEP, STEP_RESET);
        run_phase(500);
        drain();
        write_reg(CFG_STEP, 16'hFFFF);
        run_phase(300);
        drain();
        write_reg(CFG_STEP, 16'($urandom_range(65535)));
        run_phase(300);
        drain();
        write_reg(CFG_ENABLE, 16'h0000);
        write_reg(CFG_STEP, 16'($urandom_range(65535)));
        run_phase(150);
        drain();
        write_reg(CFG_ENABLE, 16'h0001);
        write_reg(CFG_STEP, 16'h0000);
        run_phase(150);
        drain();
        write_reg(CFG_STEP, 16'h0001);
        run_phase(130);
        drain();
        write_reg(CFG_STEP, 16'($urandom_range(65535)));
        run_phase(300);
        drain();

        // Leftover expectations count as failures
        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        end
        if (sb.mismatches == 0) begin
            $display("lms_adaptive_notch_unit regression: pass");
        end else begin
            $display("lms_adaptive_notch_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/lms_pkg.sv
rtl/core/lms_adaptive_notch_unit.sv
rtl/core/lms_chk.sv
sim/lms_adaptive_notch_unit_tb.sv
